// File: sv/packed_operand_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// packed operand stream decoder assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef PACKED_OPERAND_STREAM_DECODER_MACROS_SVH
`define PACKED_OPERAND_STREAM_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define POSD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("posd check failed");

// next-cycle implication, disabled during reset
`define POSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("posd check failed");

`endif

// File: sv/posd_pkg.sv
// ----------------------------------------------------------------------------
// posd_pkg
// types and constants of the packed operand stream decoder
// ----------------------------------------------------------------------------
package posd_pkg;

	localparam int ByteW  = 8;
	localparam int ValueW = 32;
	localparam int LenW   = 3;
	localparam int RemW   = 3;

	typedef enum logic [2:0] {
		FMT_POS5   = 3'd0,
		FMT_NEG5   = 3'd1,
		FMT_POS13  = 3'd2,
		FMT_NEG13  = 3'd3,
		FMT_CREG5  = 3'd4,
		FMT_CREG13 = 3'd5,
		FMT_FULL   = 3'd6,
		FMT_FULL7  = 3'd7
	} fmt_t;

	localparam logic [ValueW-1:0] MaskNeg5  = 32'hffff_ffe0;
	localparam logic [ValueW-1:0] MaskNeg13 = 32'hffff_e000;
	localparam logic [ValueW-1:0] ConstBase = 32'h4000_0000;

	localparam logic [LenW-1:0] LenShort = 3'd1;
	localparam logic [LenW-1:0] LenMid   = 3'd2;
	localparam logic [LenW-1:0] LenFull  = 3'd5;

	localparam logic [RemW-1:0] RemNone = 3'd0;
	localparam logic [RemW-1:0] RemLast = 3'd1;
	localparam logic [RemW-1:0] RemFull = 3'd4;

endpackage

// File: sv/packed_operand_stream_decoder.sv
// ----------------------------------------------------------------------------
// packed_operand_stream_decoder
// decodes a byte stream of packed 32-bit operands into values
// ----------------------------------------------------------------------------
// input channel: in_valid, in_stall, in_byte; one byte per transaction
// output channel: out_valid, out_stall, value, encoded_length
// a lead byte's top three bits pick the format: 1-byte short, 2-byte
// 13-bit, or 5-byte full little-endian value; one transaction leaves
// on the output when the last byte of an encoding has been decoded
// throughput: one byte per cycle while in_stall is low, set by the single
// decode stage; a result is decoded from the byte in the input register
// and registered in the result register, which drives the output
// when out_stall holds a waiting result, bytes that finish no value still
// pass; a byte that finishes a value waits in the input register and
// in_stall rises until the result register is free
// reset clears the valid bits and the decode state; the first byte after
// reset is a lead byte
// ----------------------------------------------------------------------------
module packed_operand_stream_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [posd_pkg::ByteW-1:0]    in_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [posd_pkg::ValueW-1:0]   value,
	output logic [posd_pkg::LenW-1:0]     encoded_length
);

	logic                          valid_s1;
	logic [posd_pkg::ByteW-1:0]    byte_s1;
	logic                          valid_s2;
	logic [posd_pkg::ValueW-1:0]   value_s2;
	logic [posd_pkg::LenW-1:0]     len_s2;

	logic [posd_pkg::RemW-1:0]     rem_q;
	posd_pkg::fmt_t                kind_q;
	logic [posd_pkg::ValueW-1:0]   acc_q;

	logic                          emit;
	logic [posd_pkg::ValueW-1:0]   emit_value;
	logic [posd_pkg::LenW-1:0]     emit_len;
	logic [posd_pkg::RemW-1:0]     rem_d;
	posd_pkg::fmt_t                kind_d;
	logic [posd_pkg::ValueW-1:0]   acc_d;
	logic                          adv;

	// decode of the byte in the input register
	always_comb begin
		posd_pkg::fmt_t             lead;
		logic [posd_pkg::ValueW-1:0] low5;
		logic [posd_pkg::ValueW-1:0] hi13;
		logic [posd_pkg::ValueW-1:0] b32;
		lead       = posd_pkg::fmt_t'(byte_s1[7:5]);
		low5       = {27'd0, byte_s1[4:0]};
		hi13       = {19'd0, byte_s1[4:0], 8'd0};
		b32        = {24'd0, byte_s1};
		emit       = 1'b0;
		emit_value = '0;
		emit_len   = posd_pkg::LenShort;
		rem_d      = rem_q;
		kind_d     = kind_q;
		acc_d      = acc_q;
		if (rem_q == posd_pkg::RemNone) begin
			unique case (lead)
				posd_pkg::FMT_POS5: begin
					emit       = 1'b1;
					emit_value = low5;
				end
				posd_pkg::FMT_NEG5: begin
					emit       = 1'b1;
					emit_value = posd_pkg::MaskNeg5 | low5;
				end
				posd_pkg::FMT_CREG5: begin
					emit       = 1'b1;
					emit_value = posd_pkg::ConstBase | low5;
				end
				posd_pkg::FMT_POS13, posd_pkg::FMT_NEG13, posd_pkg::FMT_CREG13: begin
					kind_d = lead;
					acc_d  = hi13;
					rem_d  = posd_pkg::RemLast;
				end
				posd_pkg::FMT_FULL, posd_pkg::FMT_FULL7: begin
					kind_d = lead;
					acc_d  = '0;
					rem_d  = posd_pkg::RemFull;
				end
			endcase
		end else if (kind_q == posd_pkg::FMT_POS13 || kind_q == posd_pkg::FMT_NEG13 ||
				kind_q == posd_pkg::FMT_CREG13) begin
			emit     = 1'b1;
			emit_len = posd_pkg::LenMid;
			if (kind_q == posd_pkg::FMT_NEG13) begin
				emit_value = acc_q | b32 | posd_pkg::MaskNeg13;
			end else if (kind_q == posd_pkg::FMT_CREG13) begin
				emit_value = acc_q | b32 | posd_pkg::ConstBase;
			end else begin
				emit_value = acc_q | b32;
			end
			rem_d = posd_pkg::RemNone;
			acc_d = '0;
		end else begin
			// full format: bytes land low to high
			unique case (rem_q)
				3'd4:    acc_d = acc_q | b32;
				3'd3:    acc_d = acc_q | {b32[23:0], 8'd0};
				3'd2:    acc_d = acc_q | {b32[15:0], 16'd0};
				default: acc_d = acc_q | {b32[7:0], 24'd0};
			endcase
			rem_d = rem_q - 3'd1;
			if (rem_q == posd_pkg::RemLast) begin
				emit       = 1'b1;
				emit_len   = posd_pkg::LenFull;
				emit_value = acc_d;
				acc_d      = '0;
			end
		end
	end

	assign adv      = valid_s1 && !(emit && valid_s2 && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_s1 <= '0;
		end else if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= posd_pkg::RemNone;
			kind_q <= posd_pkg::FMT_POS5;
			acc_q  <= '0;
		end else if (adv) begin
			rem_q  <= rem_d;
			kind_q <= kind_d;
			acc_q  <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && emit) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			value_s2 <= emit_value;
			len_s2   <= emit_len;
		end
	end

	assign out_valid      = valid_s2;
	assign value          = value_s2;
	assign encoded_length = len_s2;

endmodule

// File: sv/posd_checker.sv
// ----------------------------------------------------------------------------
// posd_checker
// port-level checks of the packed operand stream decoder
// ----------------------------------------------------------------------------
`include "packed_operand_stream_decoder_macros.svh"

module posd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [posd_pkg::ByteW-1:0]    in_byte,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [posd_pkg::ValueW-1:0]   value,
	input logic [posd_pkg::LenW-1:0]     encoded_length
);

	logic in_unused;
	assign in_unused = in_valid ^ in_stall ^ (^in_byte);

	// a stalled transaction holds its payload
	`POSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(value) && $stable(encoded_length))

	`POSD_ASSERT_NOW(a_len_legal, out_valid,
		encoded_length == posd_pkg::LenShort || encoded_length == posd_pkg::LenMid ||
		encoded_length == posd_pkg::LenFull)

	// short values: zero, all ones, or constant base from bit 5 up
	`POSD_ASSERT_NOW(a_short_range, out_valid && encoded_length == posd_pkg::LenShort,
		value[31:5] == 27'h0 || value[31:5] == 27'h7ff_ffff || value[31:5] == 27'h200_0000)

	// 13-bit values: zero, all ones, or constant base from bit 13 up
	`POSD_ASSERT_NOW(a_mid_range, out_valid && encoded_length == posd_pkg::LenMid,
		value[31:13] == 19'h0 || value[31:13] == 19'h7_ffff || value[31:13] == 19'h2_0000)

endmodule

bind packed_operand_stream_decoder posd_checker u_posd_checker (.*);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// packed operand stream decoder testbench
// drives byte transactions with random gaps, predicts each decoded operand
// from the byte stream and checks every output transaction field by field
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [posd_pkg::ValueW-1:0] value;
		logic [posd_pkg::LenW-1:0]   len;
	} operand_t;

	class operand_scoreboard;
		logic [posd_pkg::RemW-1:0]   rem;
		posd_pkg::fmt_t              kind;
		logic [posd_pkg::ValueW-1:0] acc;
		operand_t                    operand_q[$];
		int                          errors;

		function new();
			rem    = posd_pkg::RemNone;
			kind   = posd_pkg::FMT_POS5;
			acc    = '0;
			errors = 0;
		endfunction

		function bit decode(input logic [posd_pkg::ByteW-1:0] b, output operand_t op);
			logic [4:0] low;
			logic [1:0] pos;
			low = b[4:0];
			op.value = '0;
			op.len = '0;
			if (rem == posd_pkg::RemNone) begin
				kind = posd_pkg::fmt_t'(b[7:5]);
				case (kind)
					posd_pkg::FMT_POS5: begin
						op.value = {27'd0, low};
						op.len = posd_pkg::LenShort;
						return 1'b1;
					end
					posd_pkg::FMT_NEG5: begin
						op.value = posd_pkg::MaskNeg5 | {27'd0, low};
						op.len = posd_pkg::LenShort;
						return 1'b1;
					end
					posd_pkg::FMT_CREG5: begin
						op.value = posd_pkg::ConstBase | {27'd0, low};
						op.len = posd_pkg::LenShort;
						return 1'b1;
					end
					posd_pkg::FMT_POS13, posd_pkg::FMT_NEG13, posd_pkg::FMT_CREG13: begin
						acc = {19'd0, low, 8'd0};
						rem = posd_pkg::RemLast;
						return 1'b0;
					end
					default: begin
						acc = '0;
						rem = posd_pkg::RemFull;
						return 1'b0;
					end
				endcase
			end
			if (kind == posd_pkg::FMT_POS13 || kind == posd_pkg::FMT_NEG13 ||
					kind == posd_pkg::FMT_CREG13) begin
				op.value = acc | {24'd0, b};
				if (kind == posd_pkg::FMT_NEG13)
					op.value = op.value | posd_pkg::MaskNeg13;
				else if (kind == posd_pkg::FMT_CREG13)
					op.value = op.value | posd_pkg::ConstBase;
				op.len = posd_pkg::LenMid;
				rem = posd_pkg::RemNone;
				acc = '0;
				return 1'b1;
			end
			pos = 2'(posd_pkg::RemFull - rem);
			acc = acc | ({24'd0, b} << (8 * pos));
			rem = rem - 1'b1;
			if (rem == posd_pkg::RemNone) begin
				op.value = acc;
				op.len = posd_pkg::LenFull;
				acc = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		task note_byte(input logic [posd_pkg::ByteW-1:0] b);
			operand_t op;
			if (decode(b, op))
				operand_q.push_back(op);
		endtask

		task report(input string msg);
			errors++;
			if (errors <= 100)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(input logic [posd_pkg::ValueW-1:0] v,
				input logic [posd_pkg::LenW-1:0] len);
			operand_t op;
			if (operand_q.size() == 0) begin
				report($sformatf("unexpected value %h length %0d", v, len));
			end else begin
				op = operand_q.pop_front();
				if (v !== op.value)
					report($sformatf("value %h, expected %h", v, op.value));
				if (len !== op.len)
					report($sformatf("encoded_length %0d, expected %0d", len, op.len));
			end
		endtask

		function int pending();
			return operand_q.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [posd_pkg::ByteW-1:0]  in_byte;
	logic                        out_valid;
	logic                        out_stall;
	logic [posd_pkg::ValueW-1:0] value;
	logic [posd_pkg::LenW-1:0]   encoded_length;

	operand_scoreboard sb;
	bit                tx_idle;
	bit                rx_idle;
	int                rx_hold;
	int                bytes_sent;

	packed_operand_stream_decoder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.encoded_length (encoded_length)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(in_byte);
			if (out_valid && !out_stall)
				sb.check_result(value, encoded_length);
		end
	end

	// receiver: random hold-off per transaction, or one long hold when asked
	initial begin : receiver
		int n;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = rx_idle ? $urandom_range(0, 10) : 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task send_byte(input logic [posd_pkg::ByteW-1:0] b);
		int n;
		n = tx_idle ? $urandom_range(0, 10) : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	function logic [posd_pkg::ByteW-1:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	task send_encoding();
		logic [2:0] f;
		logic [4:0] low;
		if ($urandom_range(0, 9) == 0) begin
			send_byte(8'($urandom));
		end else begin
			f = 3'($urandom_range(0, 7));
			low = 5'(rand_byte());
			send_byte({f, low});
			case (posd_pkg::fmt_t'(f))
				posd_pkg::FMT_POS13, posd_pkg::FMT_NEG13, posd_pkg::FMT_CREG13:
					send_byte(rand_byte());
				posd_pkg::FMT_FULL, posd_pkg::FMT_FULL7:
					repeat (4) send_byte(rand_byte());
				default: ;
			endcase
		end
	endtask

	task run_random(input int count);
		int stop;
		stop = bytes_sent + count;
		while (bytes_sent < stop)
			send_encoding();
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [posd_pkg::ByteW-1:0] directed_q[$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		out_stall = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 0;
		bytes_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_q = '{8'h00, 8'h1f, 8'h20, 8'h3f, 8'h80, 8'h9f,
			8'h40, 8'h00, 8'h7f, 8'hff, 8'hbf, 8'hff,
			8'hdf, 8'hff, 8'hff, 8'hff, 8'hff,
			8'he0, 8'h78, 8'h56, 8'h34, 8'h12};
		foreach (directed_q[i])
			send_byte(directed_q[i]);

		run_random(300);

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		run_random(200);

		// long output hold while bytes keep coming
		rx_hold = 300;
		run_random(100);
		drain();

		tx_idle = 1'b1;
		rx_idle = 1'b0;
		run_random(200);

		tx_idle = 1'b0;
		rx_idle = 1'b1;
		run_random(200);

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d values never came out", sb.pending()));
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/posd_pkg.sv
sv/packed_operand_stream_decoder.sv
sv/posd_checker.sv
sim/testbench.sv
